### src/line_follower_pid_drive_core_defines.svh
// ============================================================================
// Assertion macros for the line follower drive core
// Shared helpers that keep the concurrent checks short and uniform.
// ============================================================================
`ifndef LINE_FOLLOWER_PID_DRIVE_CORE_DEFINES_SVH
`define LINE_FOLLOWER_PID_DRIVE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, quiet in reset
`define LFPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the block clock, quiet in reset
`define LFPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/lfpd_pkg.sv
// ============================================================================
// lfpd_pkg
// Shared codes, reset values and fixed-point constants of the drive core.
// ============================================================================
`timescale 1ns / 1ps

package lfpd_pkg;

    // Run modes; code 3 behaves as stopped
    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_FOLLOW = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_RUN_MODE   = 3'd0;
    localparam logic [2:0] CFG_GAIN_P     = 3'd1;
    localparam logic [2:0] CFG_GAIN_I     = 3'd2;
    localparam logic [2:0] CFG_GAIN_D     = 3'd3;
    localparam logic [2:0] CFG_BASE_SPEED = 3'd4;
    localparam logic [2:0] CFG_TARGET     = 3'd5;

    // Bridge direction codes
    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    // Register reset values
    localparam logic [7:0] RST_GAIN_P     = 8'd90;
    localparam logic [7:0] RST_GAIN_I     = 8'd17;
    localparam logic [7:0] RST_GAIN_D     = 8'd37;
    localparam logic [6:0] RST_BASE_SPEED = 7'd13;

    // Parameter defaults
    localparam int DUTY_FULL_DEF     = 100;
    localparam int INTEGRAL_BITS_DEF = 24;

    // Correction scaling: change = num / DIV_BASE, P and D terms scaled by GAIN_SCALE
    localparam int DIV_BASE   = 100000;
    localparam int GAIN_SCALE = 10000;

    // Biased partial sum: width, bias in quotient units, bias value
    localparam int YW     = 29;
    localparam int Q_BIAS = 2048;
    localparam logic signed [31:0] Y_BIAS = 32'(Q_BIAS * DIV_BASE);

    // Reciprocal of DIV_BASE for the partial-sum quotient
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP       = (1 << RECIP_SHIFT) / DIV_BASE;
    localparam int RECIPW      = 14;
    localparam int QYW         = 13;

    // Integral remainder width (holds 0 .. DIV_BASE-1)
    localparam int RW = 17;

    // Word handed from a wheel driver to the output register
    typedef struct packed {
        logic [1:0] dir;
        logic [6:0] duty;
    } t_wheel_drv;

    // Signed width of the integral quotient (integral / DIV_BASE)
    function automatic int lfpd_qw(input int bits);
        lfpd_qw = (bits - 15 > 3) ? bits - 15 : 3;
    endfunction

endpackage

### src/lfpd_pid.sv
// ============================================================================
// lfpd_pid
// Line position error, derivative, saturating integral and P/D products.
// ============================================================================
`timescale 1ns / 1ps

module lfpd_pid
    import lfpd_pkg::*;
#(
    parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_update,
    input  logic [6:0]                               i_sensor_pins,
    input  logic signed [1:0]                        i_target,
    input  logic [7:0]                               i_gain_p,
    input  logic [7:0]                               i_gain_d,
    output logic signed [5:0]                        o_err,
    output logic signed [14:0]                       o_p_term,
    output logic signed [15:0]                       o_d_term,
    output logic signed [lfpd_qw(INTEGRAL_BITS)-1:0] o_int_q,
    output logic [RW-1:0]                            o_int_r
);

    localparam int QW = lfpd_qw(INTEGRAL_BITS);

    // Integral bounds split into quotient and remainder by DIV_BASE
    localparam longint IMAX = (longint'(1) << (INTEGRAL_BITS - 1)) - 1;
    localparam longint IMAG = IMAX + 1;
    localparam longint QMAX_L = IMAX / DIV_BASE;
    localparam longint RMAX_L = IMAX % DIV_BASE;
    localparam longint QMIN_L = -((IMAG + DIV_BASE - 1) / DIV_BASE);
    localparam longint RMIN_L = QMIN_L * (-DIV_BASE) - IMAG;
    localparam logic signed [QW-1:0] QMAX = QW'(QMAX_L);
    localparam logic signed [QW-1:0] QMIN = QW'(QMIN_L);
    localparam logic [RW-1:0] RMAX = RW'(RMAX_L);
    localparam logic [RW-1:0] RMIN = RW'(RMIN_L);
    localparam logic signed [18:0] DIV19 = 19'(DIV_BASE);

    logic signed [5:0]    r_prev_err;
    logic signed [QW-1:0] r_int_q;
    logic [RW-1:0]        r_int_r;

    logic [6:0]           seen;
    logic [2:0]           pos_sum;
    logic [2:0]           neg_sum;
    logic signed [6:0]    raw;
    logic signed [6:0]    tgt;
    logic signed [6:0]    err_w;
    logic signed [6:0]    diff;
    logic signed [18:0]   rsum;
    logic signed [QW-1:0] qc;
    logic [RW-1:0]        rc;
    logic                 over;
    logic                 under;

    // Weighted line position from the outer sensors, center unused
    always_comb begin
        seen    = ~i_sensor_pins;
        pos_sum = {2'b00, seen[4]} + {1'b0, seen[5], 1'b0}
                + {2'b00, seen[6]} + {1'b0, seen[6], 1'b0};
        neg_sum = {2'b00, seen[2]} + {1'b0, seen[1], 1'b0}
                + {2'b00, seen[0]} + {1'b0, seen[0], 1'b0};
        raw     = $signed({4'b0000, pos_sum}) - $signed({4'b0000, neg_sum});
        tgt     = {{5{i_target[1]}}, i_target};
        err_w   = (tgt <<< 3) + (tgt <<< 1) - raw;
        diff    = err_w - {r_prev_err[5], r_prev_err};
    end

    // Add the error to the integral, renormalize the remainder, then clamp
    always_comb begin
        rsum = $signed({2'b00, r_int_r}) + {{13{err_w[5]}}, err_w[5:0]};
        if (rsum < 0) begin
            qc = r_int_q - QW'(1);
            rc = RW'(rsum + DIV19);
        end else if (rsum >= DIV19) begin
            qc = r_int_q + QW'(1);
            rc = RW'(rsum - DIV19);
        end else begin
            qc = r_int_q;
            rc = rsum[RW-1:0];
        end
        over  = (qc > QMAX) || ((qc == QMAX) && (rc > RMAX));
        under = (qc < QMIN) || ((qc == QMIN) && (rc < RMIN));
        if (over) begin
            o_int_q = QMAX;
            o_int_r = RMAX;
        end else if (under) begin
            o_int_q = QMIN;
            o_int_r = RMIN;
        end else begin
            o_int_q = qc;
            o_int_r = rc;
        end
    end

    // Proportional and derivative products
    assign o_err    = err_w[5:0];
    assign o_p_term = $signed({1'b0, i_gain_p}) * $signed(err_w[5:0]);
    assign o_d_term = $signed({1'b0, i_gain_d}) * diff;

    // Advance the controller state on each follow-mode word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_int_q    <= '0;
            r_int_r    <= '0;
        end else if (i_update) begin
            r_prev_err <= err_w[5:0];
            r_int_q    <= o_int_q;
            r_int_r    <= o_int_r;
        end
    end

endmodule

### src/lfpd_wheel.sv
// ============================================================================
// lfpd_wheel
// Split a signed wheel speed into a held bridge direction and a PWM duty.
// ============================================================================
`timescale 1ns / 1ps

module lfpd_wheel
    import lfpd_pkg::*;
#(
    parameter int SPEED_W   = 18,
    parameter int DUTY_FULL = DUTY_FULL_DEF
) (
    input  logic signed [SPEED_W-1:0] i_speed,
    input  logic                      i_drive,
    input  logic [1:0]                i_held_dir,
    output t_wheel_drv                o_drv
);

    localparam logic [SPEED_W-1:0] FULL = SPEED_W'(DUTY_FULL);

    logic [SPEED_W-1:0] mag;
    logic [SPEED_W-1:0] sat;

    // Magnitude saturated to full duty
    always_comb begin
        mag = i_speed[SPEED_W-1] ? SPEED_W'(-i_speed) : i_speed;
        sat = (mag > FULL) ? FULL : mag;
    end

    // Sign picks the direction, zero keeps the held one; drive off holds it with zero duty
    always_comb begin
        o_drv.dir  = i_held_dir;
        o_drv.duty = '0;
        if (i_drive) begin
            o_drv.duty = sat[6:0];
            if (i_speed > 0) begin
                o_drv.dir = DIR_FWD;
            end else if (i_speed < 0) begin
                o_drv.dir = DIR_REV;
            end
        end
    end

endmodule

### src/line_follower_pid_drive_core.sv
// Line follower PID differential drive. One word per control tick carries the
// seven active-low sensor pins and two manual wheel speeds; one result word of
// bridge directions, duties and the position error comes back for each. The
// block takes a word every clock cycle unless o_in_stall is high; a six-register
// pipeline (input, error/integral update, partial sum, reciprocal quotient,
// remainder fix-up, wheel drive) carries each word, and the integral update
// sets the rate of one word per cycle while nothing stalls. A stalled output
// lets the empty stages keep filling before input stalls. The user must write
// configuration only while no word is in flight; the block itself leaves it unchecked.
// ============================================================================
// line_follower_pid_drive_core
// Top level: configuration registers, handshake pipeline and PID correction.
// ============================================================================
`timescale 1ns / 1ps

module line_follower_pid_drive_core
    import lfpd_pkg::*;
#(
    parameter int DUTY_FULL     = DUTY_FULL_DEF,
    parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [6:0]        i_sensor_pins,
    input  logic signed [7:0] i_manual_left,
    input  logic signed [7:0] i_manual_right,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_left_direction,
    output logic [6:0]        o_left_duty,
    output logic [1:0]        o_right_direction,
    output logic [6:0]        o_right_duty,
    output logic signed [5:0] o_error_tenths
);

    `include "line_follower_pid_drive_core_defines.svh"

    localparam int QW   = lfpd_qw(INTEGRAL_BITS);
    localparam int GQW  = QW + 9;
    localparam int CW   = ((GQW > QYW + 1) ? GQW : QYW + 1) + 2;
    localparam int SW   = (CW + 1 > 18) ? CW + 1 : 18;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]        r_run_mode;
    logic [7:0]        r_gain_p;
    logic [7:0]        r_gain_i;
    logic [7:0]        r_gain_d;
    logic [6:0]        r_base_speed;
    logic signed [1:0] r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_mode   <= MODE_MANUAL;
            r_gain_p     <= RST_GAIN_P;
            r_gain_i     <= RST_GAIN_I;
            r_gain_d     <= RST_GAIN_D;
            r_base_speed <= RST_BASE_SPEED;
            r_target     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RUN_MODE:   r_run_mode   <= i_cfg_data[1:0];
                CFG_GAIN_P:     r_gain_p     <= i_cfg_data;
                CFG_GAIN_I:     r_gain_i     <= i_cfg_data;
                CFG_GAIN_D:     r_gain_d     <= i_cfg_data;
                CFG_BASE_SPEED: r_base_speed <= i_cfg_data[6:0];
                CFG_TARGET:     r_target     <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    logic mode_follow;
    logic mode_manual;

    assign mode_follow = (r_run_mode == MODE_FOLLOW);
    assign mode_manual = (r_run_mode == MODE_MANUAL);

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_s3_valid;
    logic r_s4_valid;
    logic r_s5_valid;
    logic r_out_valid;
    logic rdy_out;
    logic rdy5;
    logic rdy4;
    logic rdy3;
    logic rdy2;
    logic rdy1;

    assign rdy_out    = !r_out_valid || !i_out_stall;
    assign rdy5       = !r_s5_valid || rdy_out;
    assign rdy4       = !r_s4_valid || rdy5;
    assign rdy3       = !r_s3_valid || rdy4;
    assign rdy2       = !r_s2_valid || rdy3;
    assign rdy1       = !r_s1_valid || rdy2;
    assign o_in_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_valid <= i_in_valid;
            end
            if (rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (rdy4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (rdy5) begin
                r_s5_valid <= r_s4_valid;
            end
            if (rdy_out) begin
                r_out_valid <= r_s5_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input word
    // ------------------------------------------------------------------
    logic [6:0]        r_s1_pins;
    logic signed [7:0] r_s1_ml;
    logic signed [7:0] r_s1_mr;

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) begin
            r_s1_pins <= i_sensor_pins;
            r_s1_ml   <= i_manual_left;
            r_s1_mr   <= i_manual_right;
        end
    end

    // Error, integral and P/D products; state advances on follow words
    logic signed [5:0]    w_err;
    logic signed [14:0]   w_p_term;
    logic signed [15:0]   w_d_term;
    logic signed [QW-1:0] w_int_q;
    logic [RW-1:0]        w_int_r;
    logic                 pid_update;

    assign pid_update = r_s1_valid && rdy2 && mode_follow;

    lfpd_pid #(
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_pid (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_update      (pid_update),
        .i_sensor_pins (r_s1_pins),
        .i_target      (r_target),
        .i_gain_p      (r_gain_p),
        .i_gain_d      (r_gain_d),
        .o_err         (w_err),
        .o_p_term      (w_p_term),
        .o_d_term      (w_d_term),
        .o_int_q       (w_int_q),
        .o_int_r       (w_int_r)
    );

    // ------------------------------------------------------------------
    // Stage 2: products and new integral
    // ------------------------------------------------------------------
    logic signed [5:0]    r_s2_err;
    logic signed [14:0]   r_s2_p;
    logic signed [15:0]   r_s2_d;
    logic signed [QW-1:0] r_s2_q;
    logic [RW-1:0]        r_s2_r;
    logic signed [7:0]    r_s2_ml;
    logic signed [7:0]    r_s2_mr;

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_s1_valid) begin
            r_s2_err <= mode_follow ? w_err : 6'sd0;
            r_s2_p   <= w_p_term;
            r_s2_d   <= w_d_term;
            r_s2_q   <= w_int_q;
            r_s2_r   <= w_int_r;
            r_s2_ml  <= r_s1_ml;
            r_s2_mr  <= r_s1_mr;
        end
    end

    // Biased partial sum GAIN_SCALE*(P+D) + gi*rem, and gi*quot
    logic signed [16:0]    pd_sum;
    logic signed [31:0]    pd_ext;
    logic [24:0]           gi_rem;
    logic signed [31:0]    y_sum;
    logic signed [GQW-1:0] gi_quot;

    always_comb begin
        pd_sum  = {{2{r_s2_p[14]}}, r_s2_p} + {r_s2_d[15], r_s2_d};
        pd_ext  = {{15{pd_sum[16]}}, pd_sum};
        gi_rem  = r_gain_i * r_s2_r;
        y_sum   = pd_ext * 32'(GAIN_SCALE) + $signed({7'b0, gi_rem}) + Y_BIAS;
        gi_quot = $signed({1'b0, r_gain_i}) * r_s2_q;
    end

    // ------------------------------------------------------------------
    // Stage 3: partial sum
    // ------------------------------------------------------------------
    logic [YW-1:0]         r_s3_y;
    logic signed [GQW-1:0] r_s3_gq;
    logic signed [5:0]     r_s3_err;
    logic signed [7:0]     r_s3_ml;
    logic signed [7:0]     r_s3_mr;

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_s2_valid) begin
            r_s3_y   <= y_sum[YW-1:0];
            r_s3_gq  <= gi_quot;
            r_s3_err <= r_s2_err;
            r_s3_ml  <= r_s2_ml;
            r_s3_mr  <= r_s2_mr;
        end
    end

    // Reciprocal estimate of the quotient, low by at most one
    logic [YW+RECIPW-1:0] y_prod;

    assign y_prod = (YW + RECIPW)'(r_s3_y) * (YW + RECIPW)'(RECIP);

    // ------------------------------------------------------------------
    // Stage 4: quotient estimate
    // ------------------------------------------------------------------
    logic [YW-1:0]         r_s4_y;
    logic [QYW-1:0]        r_s4_q0;
    logic signed [GQW-1:0] r_s4_gq;
    logic signed [5:0]     r_s4_err;
    logic signed [7:0]     r_s4_ml;
    logic signed [7:0]     r_s4_mr;

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_s3_valid) begin
            r_s4_y   <= r_s3_y;
            r_s4_q0  <= y_prod[RECIP_SHIFT +: QYW];
            r_s4_gq  <= r_s3_gq;
            r_s4_err <= r_s3_err;
            r_s4_ml  <= r_s3_ml;
            r_s4_mr  <= r_s3_mr;
        end
    end

    // Fix the quotient, remove the bias, round the total toward zero
    logic [YW:0]          q_mul;
    logic [17:0]          rem0;
    logic [17:0]          rem;
    logic [QYW-1:0]       q_fix;
    logic signed [QYW:0]  q_y;
    logic signed [CW-1:0] floor_sum;
    logic signed [CW-1:0] change;

    always_comb begin
        q_mul = (YW + 1)'(r_s4_q0) * (YW + 1)'(DIV_BASE);
        rem0  = 18'((YW + 1)'(r_s4_y) - q_mul);
        if (rem0 >= 18'(DIV_BASE)) begin
            q_fix = r_s4_q0 + QYW'(1);
            rem   = rem0 - 18'(DIV_BASE);
        end else begin
            q_fix = r_s4_q0;
            rem   = rem0;
        end
        q_y       = $signed({1'b0, q_fix}) - (QYW + 1)'(Q_BIAS);
        floor_sum = CW'(r_s4_gq) + CW'(q_y);
        change    = floor_sum;
        if (floor_sum < 0 && rem != '0) begin
            change = floor_sum + CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: steering correction
    // ------------------------------------------------------------------
    logic signed [CW-1:0] r_s5_change;
    logic signed [5:0]    r_s5_err;
    logic signed [7:0]    r_s5_ml;
    logic signed [7:0]    r_s5_mr;

    always_ff @(posedge i_clk) begin
        if (rdy5 && r_s4_valid) begin
            r_s5_change <= change;
            r_s5_err    <= r_s4_err;
            r_s5_ml     <= r_s4_ml;
            r_s5_mr     <= r_s4_mr;
        end
    end

    // Wheel speeds for the active mode
    logic signed [SW-1:0] base_ext;
    logic signed [SW-1:0] chg_ext;
    logic signed [SW-1:0] left_speed;
    logic signed [SW-1:0] right_speed;
    logic                 drive_on;

    always_comb begin
        base_ext = $signed({{(SW - 7){1'b0}}, r_base_speed});
        chg_ext  = SW'(r_s5_change);
        if (mode_follow) begin
            left_speed  = base_ext - chg_ext;
            right_speed = base_ext + chg_ext;
        end else begin
            left_speed  = {{(SW - 8){r_s5_ml[7]}}, r_s5_ml};
            right_speed = {{(SW - 8){r_s5_mr[7]}}, r_s5_mr};
        end
        drive_on = mode_follow || mode_manual;
    end

    t_wheel_drv left_drv;
    t_wheel_drv right_drv;

    lfpd_wheel #(
        .SPEED_W   (SW),
        .DUTY_FULL (DUTY_FULL)
    ) u_wheel_left (
        .i_speed    (left_speed),
        .i_drive    (drive_on),
        .i_held_dir (o_left_direction),
        .o_drv      (left_drv)
    );

    lfpd_wheel #(
        .SPEED_W   (SW),
        .DUTY_FULL (DUTY_FULL)
    ) u_wheel_right (
        .i_speed    (right_speed),
        .i_drive    (drive_on),
        .i_held_dir (o_right_direction),
        .o_drv      (right_drv)
    );

    // ------------------------------------------------------------------
    // Output register; the direction registers double as held direction
    // ------------------------------------------------------------------
    logic [1:0]        r_out_ldir;
    logic [1:0]        r_out_rdir;
    logic [6:0]        r_out_lduty;
    logic [6:0]        r_out_rduty;
    logic signed [5:0] r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ldir <= DIR_OFF;
            r_out_rdir <= DIR_OFF;
        end else if (rdy_out && r_s5_valid) begin
            r_out_ldir <= left_drv.dir;
            r_out_rdir <= right_drv.dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out && r_s5_valid) begin
            r_out_lduty <= left_drv.duty;
            r_out_rduty <= right_drv.duty;
            r_out_err   <= r_s5_err;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_left_direction  = r_out_ldir;
    assign o_left_duty       = r_out_lduty;
    assign o_right_direction = r_out_rdir;
    assign o_right_duty      = r_out_rduty;
    assign o_error_tenths    = r_out_err;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `LFPD_ASSERT_NOW(a_int_rem_range, r_s1_valid, w_int_r < RW'(DIV_BASE), "integral remainder out of range")
    `LFPD_ASSERT_NOW(a_duty_has_dir, o_out_valid && (o_left_duty != '0), o_left_direction != DIR_OFF, "left duty without direction")
    `LFPD_ASSERT_NEXT(a_s5_holds, r_s5_valid && r_out_valid && i_out_stall, r_s5_valid, "stage five lost a word under stall")

endmodule

### test/line_follower_pid_drive_checker.sv
// ============================================================================
// line_follower_pid_drive_checker
// Watches the configuration port and both word channels of the drive core,
// predicts each result word from its own copy of the PID and wheel state,
// and compares every accepted result word field by field, oldest first.
// ============================================================================
`timescale 1ns / 1ps

module line_follower_pid_drive_checker
    import lfpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    // input channel
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [6:0]        i_sensor_pins,
    input  logic signed [7:0] i_manual_left,
    input  logic signed [7:0] i_manual_right,
    // output channel
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [1:0]        i_left_direction,
    input  logic [6:0]        i_left_duty,
    input  logic [1:0]        i_right_direction,
    input  logic [6:0]        i_right_duty,
    input  logic signed [5:0] i_error_tenths,
    // status for the testbench top
    output int                o_fail_count,
    output int                o_pending
);

    localparam longint INTEGRAL_MAX = (64'sd1 <<< (INTEGRAL_BITS_DEF - 1)) - 1;
    localparam longint INTEGRAL_MIN = -INTEGRAL_MAX - 1;

    typedef struct packed {
        t_wheel_drv left;
        t_wheel_drv right;
        logic [5:0] err;
    } t_drive_word;

    // Register copies
    logic [1:0]        run_mode;
    logic [7:0]        kp;
    logic [7:0]        ki;
    logic [7:0]        kd;
    logic [6:0]        base;
    logic signed [1:0] target;

    // Controller state
    longint     last_error;
    longint     integral;
    logic [1:0] left_held;
    logic [1:0] right_held;

    t_drive_word expected_drive_q[$];

    // Split a signed speed into a bridge direction and a saturated duty
    function automatic t_wheel_drv wheel_drive(longint speed, logic [1:0] held);
        t_wheel_drv w;
        longint     mag;
        w.dir = held;
        mag   = 0;
        if (speed > 0) begin
            w.dir = DIR_FWD;
            mag   = speed;
        end else if (speed < 0) begin
            w.dir = DIR_REV;
            mag   = -speed;
        end
        if (mag > DUTY_FULL_DEF)
            mag = DUTY_FULL_DEF;
        w.duty = mag[6:0];
        return w;
    endfunction

    // Advance the controller by one tick and return the drive word it yields
    function automatic t_drive_word next_drive(logic [6:0] pins,
                                               logic signed [7:0] spd_l,
                                               logic signed [7:0] spd_r);
        t_drive_word w;
        logic [6:0]  seen;
        longint      raw;
        longint      err;
        longint      diff;
        longint      acc;
        longint      num;
        longint      change;
        seen = ~pins;
        raw  = 0;
        err  = 0;
        case (run_mode)
            MODE_FOLLOW: begin
                // weighted position, centre sensor ignored
                if (seen[0]) raw -= 3;
                if (seen[1]) raw -= 2;
                if (seen[2]) raw -= 1;
                if (seen[4]) raw += 1;
                if (seen[5]) raw += 2;
                if (seen[6]) raw += 3;
                err  = 10 * longint'(target) - raw;
                diff = err - last_error;
                acc  = integral + err;
                if (acc > INTEGRAL_MAX) acc = INTEGRAL_MAX;
                if (acc < INTEGRAL_MIN) acc = INTEGRAL_MIN;
                num = longint'(GAIN_SCALE) * longint'(kp) * err
                    + longint'(ki) * acc
                    + longint'(GAIN_SCALE) * longint'(kd) * diff;
                change     = num / DIV_BASE;
                last_error = err;
                integral   = acc;
                w.left  = wheel_drive(longint'(base) - change, left_held);
                w.right = wheel_drive(longint'(base) + change, right_held);
            end
            MODE_MANUAL: begin
                w.left  = wheel_drive(longint'(spd_l), left_held);
                w.right = wheel_drive(longint'(spd_r), right_held);
            end
            default: begin
                // stopped: hold directions, zero duty
                w.left.dir   = left_held;
                w.left.duty  = '0;
                w.right.dir  = right_held;
                w.right.duty = '0;
            end
        endcase
        left_held  = w.left.dir;
        right_held = w.right.dir;
        w.err      = err[5:0];
        return w;
    endfunction

    function automatic void check_field(string name, logic signed [7:0] want,
                                        logic signed [7:0] got);
        if (got !== want) begin
            o_fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_drive_word want;
        if (!i_rst_n) begin
            run_mode     = MODE_MANUAL;
            kp           = RST_GAIN_P;
            ki           = RST_GAIN_I;
            kd           = RST_GAIN_D;
            base         = RST_BASE_SPEED;
            target       = '0;
            last_error   = 0;
            integral     = 0;
            left_held    = DIR_OFF;
            right_held   = DIR_OFF;
            o_fail_count = 0;
            expected_drive_q.delete();
        end else begin
            // mirror register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RUN_MODE:   run_mode = i_cfg_data[1:0];
                    CFG_GAIN_P:     kp       = i_cfg_data;
                    CFG_GAIN_I:     ki       = i_cfg_data;
                    CFG_GAIN_D:     kd       = i_cfg_data;
                    CFG_BASE_SPEED: base     = i_cfg_data[6:0];
                    CFG_TARGET:     target   = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            // predict on every accepted input word
            if (i_in_valid && !i_in_stall)
                expected_drive_q.push_back(next_drive(i_sensor_pins, i_manual_left,
                                                      i_manual_right));
            // compare every accepted result word against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_drive_q.size() == 0) begin
                    o_fail_count++;
                    $error("result word with no expected word pending");
                end else begin
                    want = expected_drive_q.pop_front();
                    check_field("left_direction", want.left.dir, i_left_direction);
                    check_field("left_duty", want.left.duty, i_left_duty);
                    check_field("right_direction", want.right.dir, i_right_direction);
                    check_field("right_duty", want.right.duty, i_right_duty);
                    check_field("error_tenths", $signed(want.err), i_error_tenths);
                end
            end
        end
        o_pending = expected_drive_q.size();
    end

endmodule

### test/line_follower_pid_drive_core_tb.sv
// ============================================================================
// line_follower_pid_drive_core_tb
// Drives control ticks into the drive core through directed corner cases,
// randomized register settings and a steady integral ramp, with random gaps and
// output stalls; a checker beside the core predicts and compares each word.
// ============================================================================
`timescale 1ns / 1ps

module line_follower_pid_drive_core_tb;
    import lfpd_pkg::*;

    localparam logic [1:0] MODE_SPARE       = 2'd3;   // unused code, acts as stop
    localparam logic [1:0] TARGET_MINUS_TWO = 2'b10;  // read as -2 by the core
    localparam logic [6:0] SOAK_PINS        = 7'h0F;  // outer right sensors see line
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 40_000;
    localparam int SOAK_WORDS    = 60;
    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_WORDS = 140;
    localparam int IDLE_PCT      = 28;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_index;
    logic [7:0]        i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [6:0]        i_sensor_pins;
    logic signed [7:0] i_manual_left;
    logic signed [7:0] i_manual_right;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_left_direction;
    logic [6:0]        o_left_duty;
    logic [1:0]        o_right_direction;
    logic [6:0]        o_right_duty;
    logic signed [5:0] o_error_tenths;

    int          fail_count;
    int          words_in_flight;
    bit          quiet_run = 1'b0;
    int unsigned cycle_count = 0;

    line_follower_pid_drive_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_sensor_pins     (i_sensor_pins),
        .i_manual_left     (i_manual_left),
        .i_manual_right    (i_manual_right),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_left_direction  (o_left_direction),
        .o_left_duty       (o_left_duty),
        .o_right_direction (o_right_direction),
        .o_right_duty      (o_right_duty),
        .o_error_tenths    (o_error_tenths)
    );

    line_follower_pid_drive_checker u_drive_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_sensor_pins     (i_sensor_pins),
        .i_manual_left     (i_manual_left),
        .i_manual_right    (i_manual_right),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_left_direction  (o_left_direction),
        .i_left_duty       (o_left_duty),
        .i_right_direction (o_right_direction),
        .i_right_duty      (o_right_duty),
        .i_error_tenths    (o_error_tenths),
        .o_fail_count      (fail_count),
        .o_pending         (words_in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Random output back-pressure, off during quiet stretches
    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && !quiet_run && ($urandom_range(99) < IDLE_PCT);
    end

    // Hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one word after a random gap, hold it until accepted
    task automatic send_word(input logic [6:0] pins, input logic [7:0] spd_l,
                             input logic [7:0] spd_r);
        int gap;
        gap = 0;
        while (!quiet_run && $urandom_range(99) < IDLE_PCT)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sensor_pins  <= pins;
        i_manual_left  <= spd_l;
        i_manual_right <= spd_r;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (words_in_flight != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
    endtask

    // Write every register while idle; spare upper data bits are random
    task automatic set_regs(input logic [1:0] mode, input logic [7:0] gp,
                            input logic [7:0] gi, input logic [7:0] gd,
                            input logic [6:0] base, input logic [1:0] tgt);
        drain();
        write_reg(CFG_RUN_MODE, {6'($urandom), mode});
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_BASE_SPEED, {1'($urandom), base});
        write_reg(CFG_TARGET, {6'($urandom), tgt});
        i_cfg_we <= 1'b0;
    endtask

    // Mostly a plausible line under one or two sensors, else any pattern
    function automatic logic [6:0] line_pins();
        logic [6:0] seen;
        int         pos;
        if ($urandom_range(99) < 60) begin
            pos  = $urandom_range(6);
            seen = 7'b1 << pos;
            if ($urandom_range(1) == 1)
                seen = seen | (seen << 1);
            return ~seen;
        end
        return 7'($urandom);
    endfunction

    function automatic logic [7:0] pick_gain();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 8'd0;
        if (r < 30) return 8'd255;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] manual_speed();
        if ($urandom_range(99) < 20) return 8'd0;
        return 8'($urandom);
    endfunction

    initial begin
        int         r;
        logic [1:0] mode;
        logic [6:0] base;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_sensor_pins  = 7'h7F;
        i_manual_left  = '0;
        i_manual_right = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Manual drive at reset settings: zero from off, extremes, saturation
        send_word(7'h55, 8'd0, 8'd0);
        send_word(7'h2A, 8'h7F, 8'h80);
        send_word(7'h7F, 8'd0, 8'd0);
        send_word(7'h00, 8'hFF, 8'd1);
        send_word(7'h7F, 8'd100, 8'h9C);
        send_word(7'h7F, 8'd101, 8'h9B);

        // Follow mode at reset gains: no line, full line, outer and centre sensors
        set_regs(MODE_FOLLOW, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_BASE_SPEED, 2'b00);
        send_word(7'h7F, 8'd5, 8'd5);
        send_word(7'h00, 8'd5, 8'd5);
        send_word(7'h7E, 8'd5, 8'd5);
        send_word(7'h3F, 8'd5, 8'd5);
        send_word(7'h77, 8'd5, 8'd5);
        send_word(7'h78, 8'd5, 8'd5);
        send_word(7'h0F, 8'd5, 8'd5);

        // Stop and the spare mode code hold directions with zero duty
        set_regs(MODE_STOP, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_BASE_SPEED, 2'b00);
        send_word(7'h00, 8'h80, 8'h7F);
        send_word(7'h7E, 8'd0, 8'd0);
        set_regs(MODE_SPARE, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_BASE_SPEED, 2'b00);
        send_word(7'h0F, 8'h7F, 8'h80);
        send_word(7'h78, 8'd0, 8'd0);

        // Maximum gains, target at minus two then plus one, base at both ends
        set_regs(MODE_FOLLOW, 8'd255, 8'd255, 8'd255, 7'd0, TARGET_MINUS_TWO);
        send_word(7'h0F, 8'd0, 8'd0);
        send_word(7'h78, 8'd0, 8'd0);
        send_word(7'h7F, 8'd0, 8'd0);
        set_regs(MODE_FOLLOW, 8'd255, 8'd255, 8'd255, 7'd100, 2'b01);
        send_word(7'h78, 8'd0, 8'd0);
        send_word(7'h78, 8'd0, 8'd0);

        // Random segments, one register setting each; one segment runs flat out
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 0) begin
                set_regs(MODE_FOLLOW, 8'd0, 8'd0, 8'd0, 7'd100, 2'($urandom));
            end else begin
                r    = $urandom_range(99);
                mode = (r < 50) ? MODE_FOLLOW :
                       (r < 75) ? MODE_MANUAL :
                       (r < 90) ? MODE_STOP : MODE_SPARE;
                r    = $urandom_range(99);
                base = (r < 15) ? 7'd0 : (r < 30) ? 7'd100 : 7'($urandom_range(100));
                set_regs(mode, pick_gain(), pick_gain(), pick_gain(), base, 2'($urandom));
            end
            quiet_run <= (seg == 5);
            repeat (SEGMENT_WORDS)
                send_word(line_pins(), manual_speed(), manual_speed());
        end

        // Hold the line at the far edge so the integral ramps down, then move off it
        set_regs(MODE_FOLLOW, 8'd1, 8'd255, 8'd1, 7'd50, TARGET_MINUS_TWO);
        quiet_run <= 1'b1;
        repeat (SOAK_WORDS)
            send_word(SOAK_PINS, manual_speed(), manual_speed());
        quiet_run <= 1'b0;
        repeat (40)
            send_word(line_pins(), manual_speed(), manual_speed());

        drain();
        if (fail_count == 0 && words_in_flight == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
